/* rtl/core/wavp_pkg.sv */
package wavp_pkg;

	// result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_EMPTY  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [3:0] ERR_SHORT        = 4'd0;
	localparam logic [3:0] ERR_NOT_RIFF     = 4'd1;
	localparam logic [3:0] ERR_NOT_WAVE     = 4'd2;
	localparam logic [3:0] ERR_OVERRUN      = 4'd3;
	localparam logic [3:0] ERR_DUP_FMT      = 4'd4;
	localparam logic [3:0] ERR_FMT_SHORT    = 4'd5;
	localparam logic [3:0] ERR_NOT_PCM      = 4'd6;
	localparam logic [3:0] ERR_NOT_16       = 4'd7;
	localparam logic [3:0] ERR_ZERO         = 4'd8;
	localparam logic [3:0] ERR_DATA_NO_FMT  = 4'd9;
	localparam logic [3:0] ERR_NO_FMT       = 4'd10;
	localparam logic [3:0] ERR_NO_DATA      = 4'd11;

	// four-character tags, first byte in the top
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] HEADER_BYTES  = 32'd12;
	localparam logic [32:0] FMT_MIN_BYTES = 33'd16;
	localparam logic [33:0] CHDR_ROOM     = 34'd9;

	localparam logic [15:0] FMT_PCM       = 16'd1;
	localparam logic [15:0] FMT_BITS      = 16'd16;

endpackage

/* rtl/core/wav_pcm16_stream_parser.sv */
// RIFF/WAVE PCM16 byte-stream parser.
// Input channel: one file byte per word on data_byte (in_valid/in_ready).
// Output channel: one result per word (out_valid/out_ready): a sample
// (kind 0, is_last on the final one), an empty data chunk (kind 1) or an
// error (kind 2 with error_code). channel_count and rate_hz carry the fmt
// values parsed so far in every result.
// Write the total file size into file_length (cfg_we) before the file; the
// write also restarts the parser at offset 0. After file_length bytes the
// parser starts over on its own for the next file.
// Throughput: one byte per clock unless a stalled receiver holds the result
// register, set by the single state-update stage. A byte taken waits in the
// input stage, then is decoded into the parser state and the result register.
// A stalled receiver holds the result register; the input stage keeps one
// byte and in_ready drops only when both stages are full.
// Reset clears file_length to zero and all parser state; with file_length
// zero every byte gives a short-file error.
module wav_pcm16_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        file_length,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [15:0] sample,
	output logic               is_last,
	output logic [3:0]         error_code,
	output logic [15:0]        channel_count,
	output logic [31:0]        rate_hz
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_CHDR   = 3'd1;
	localparam logic [2:0] PH_FMT    = 3'd2;
	localparam logic [2:0] PH_SKIP   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// result stage
	logic        valid_s2;
	logic [1:0]  kind_s2;
	logic [15:0] sample_s2;
	logic        last_s2;
	logic [3:0]  code_s2;
	logic [15:0] chan_s2;
	logic [31:0] rate_s2;

	// parser state
	logic [31:0] file_len_q;
	logic [31:0] rem_q;        // file_len_q minus current byte offset
	logic [2:0]  phase_q;
	logic [3:0]  fs_q;
	logic [32:0] cr_q;
	logic        fmt_seen_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic [7:0]  low_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [31:0] word_q;

	logic [2:0]  phase_d;
	logic [3:0]  fs_d;
	logic [32:0] cr_d;
	logic        fmt_seen_d;
	logic [15:0] chan_d;
	logic [31:0] rate_d;
	logic [7:0]  low_d;
	logic [31:0] tag_d;
	logic [31:0] len_d;
	logic [31:0] word_d;

	logic        res_valid;
	logic [1:0]  res_kind;
	logic [15:0] res_sample;
	logic        res_last;
	logic [3:0]  res_code;

	logic        adv;
	logic        step;
	logic        restart;

	logic [31:0] tag_new;
	logic [31:0] len_new;
	logic [1:0]  wpos;
	logic [31:0] word_new;
	logic        len_pad;
	logic        len_over;
	logic [32:0] ac_rest;
	logic        ac_fail;
	logic [32:0] cr_data;
	logic [3:0]  ac_code;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;
	assign restart  = rem_q <= 32'd1;

	assign tag_new  = {tag_q[23:0], byte_s1};
	assign len_new  = len_q | ({24'd0, byte_s1} << {fs_q[1:0], 3'b000});
	assign len_pad  = len_new[0];
	assign len_over = len_new >= rem_q;
	assign wpos     = (fs_q[3:2] == 2'b01) ? fs_q[1:0] : {1'b0, fs_q[0]};
	assign word_new = ((wpos == 2'd0) ? 32'd0 : word_q)
		| ({24'd0, byte_s1} << {wpos, 3'b000});
	assign cr_data  = (cr_q >= 33'd2) ? cr_q - 33'd2 : 33'd0;
	assign ac_code  = fmt_seen_q ? wavp_pkg::ERR_NO_DATA : wavp_pkg::ERR_NO_FMT;

	// bytes to skip before the next chunk header, and whether that header fits
	always_comb begin
		unique case (phase_q)
			PH_CHDR: ac_rest = {1'b0, len_new} + {32'd0, len_pad};
			PH_FMT:  ac_rest = cr_q;
			default: ac_rest = 33'd0;
		endcase
		ac_fail = ({1'b0, ac_rest} + wavp_pkg::CHDR_ROOM) > {2'd0, rem_q};
	end

	always_comb begin
		phase_d    = phase_q;
		fs_d       = fs_q;
		cr_d       = cr_q;
		fmt_seen_d = fmt_seen_q;
		chan_d     = chan_q;
		rate_d     = rate_q;
		low_d      = low_q;
		tag_d      = tag_q;
		len_d      = len_q;
		word_d     = word_q;
		res_valid  = 1'b0;
		res_kind   = wavp_pkg::KIND_SAMPLE;
		res_sample = 16'd0;
		res_last   = 1'b0;
		res_code   = wavp_pkg::ERR_SHORT;

		unique case (phase_q)
			PH_HEADER: begin
				// fs_q counts the header bytes
				fs_d  = fs_q + 4'd1;
				tag_d = tag_new;
				if (fs_q == 4'd0 && file_len_q < wavp_pkg::HEADER_BYTES) begin
					res_valid = 1'b1;
					res_kind  = wavp_pkg::KIND_ERROR;
					res_code  = wavp_pkg::ERR_SHORT;
					phase_d   = PH_DONE;
				end else if (fs_q == 4'd3 && tag_new != wavp_pkg::TAG_RIFF) begin
					res_valid = 1'b1;
					res_kind  = wavp_pkg::KIND_ERROR;
					res_code  = wavp_pkg::ERR_NOT_RIFF;
					phase_d   = PH_DONE;
				end else if (fs_q == 4'd11) begin
					if (tag_new != wavp_pkg::TAG_WAVE || ac_fail) begin
						res_valid = 1'b1;
						res_kind  = wavp_pkg::KIND_ERROR;
						res_code  = (tag_new != wavp_pkg::TAG_WAVE)
							? wavp_pkg::ERR_NOT_WAVE : ac_code;
						phase_d   = PH_DONE;
					end else begin
						cr_d    = 33'd0;
						fs_d    = 4'd0;
						tag_d   = 32'd0;
						len_d   = 32'd0;
						phase_d = PH_CHDR;
					end
				end
			end
			PH_CHDR: begin
				fs_d = fs_q + 4'd1;
				if (fs_q < 4'd4) begin
					tag_d = tag_new;
				end else begin
					len_d = len_new;
				end
				if (fs_q == 4'd7) begin
					if (len_over) begin
						res_valid = 1'b1;
						res_kind  = wavp_pkg::KIND_ERROR;
						res_code  = wavp_pkg::ERR_OVERRUN;
						phase_d   = PH_DONE;
					end else if (tag_q == wavp_pkg::TAG_FMT) begin
						if (fmt_seen_q || {1'b0, len_new} < wavp_pkg::FMT_MIN_BYTES) begin
							res_valid = 1'b1;
							res_kind  = wavp_pkg::KIND_ERROR;
							res_code  = fmt_seen_q ? wavp_pkg::ERR_DUP_FMT
								: wavp_pkg::ERR_FMT_SHORT;
							phase_d   = PH_DONE;
						end else begin
							cr_d    = {1'b0, len_new} - wavp_pkg::FMT_MIN_BYTES
								+ {32'd0, len_pad};
							fs_d    = 4'd0;
							word_d  = 32'd0;
							phase_d = PH_FMT;
						end
					end else if (tag_q == wavp_pkg::TAG_DATA) begin
						if (!fmt_seen_q) begin
							res_valid = 1'b1;
							res_kind  = wavp_pkg::KIND_ERROR;
							res_code  = wavp_pkg::ERR_DATA_NO_FMT;
							phase_d   = PH_DONE;
						end else begin
							cr_d = {1'b0, len_new[31:1], 1'b0};
							fs_d = 4'd0;
							if (len_new[31:1] == 31'd0) begin
								res_valid = 1'b1;
								res_kind  = wavp_pkg::KIND_EMPTY;
								phase_d   = PH_DONE;
							end else begin
								phase_d = PH_DATA;
							end
						end
					end else if (ac_fail) begin
						res_valid = 1'b1;
						res_kind  = wavp_pkg::KIND_ERROR;
						res_code  = ac_code;
						phase_d   = PH_DONE;
					end else begin
						// unknown chunk: skip body and pad byte
						cr_d    = ac_rest;
						fs_d    = 4'd0;
						tag_d   = 32'd0;
						len_d   = 32'd0;
						phase_d = (ac_rest == 33'd0) ? PH_CHDR : PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				word_d = word_new;
				fs_d   = fs_q + 4'd1;
				if (fs_q == 4'd1) begin
					if (word_new[15:0] != wavp_pkg::FMT_PCM || word_new[31:16] != 16'd0) begin
						res_valid = 1'b1;
						res_kind  = wavp_pkg::KIND_ERROR;
						res_code  = wavp_pkg::ERR_NOT_PCM;
						phase_d   = PH_DONE;
					end
				end else if (fs_q == 4'd3) begin
					chan_d = word_new[15:0];
				end else if (fs_q == 4'd7) begin
					rate_d = word_new;
				end else if (fs_q == 4'd15) begin
					if (word_new[15:0] != wavp_pkg::FMT_BITS || word_new[31:16] != 16'd0) begin
						res_valid = 1'b1;
						res_kind  = wavp_pkg::KIND_ERROR;
						res_code  = wavp_pkg::ERR_NOT_16;
						phase_d   = PH_DONE;
					end else if (chan_q == 16'd0 || rate_q == 32'd0) begin
						res_valid = 1'b1;
						res_kind  = wavp_pkg::KIND_ERROR;
						res_code  = wavp_pkg::ERR_ZERO;
						phase_d   = PH_DONE;
					end else begin
						fmt_seen_d = 1'b1;
						if (ac_fail) begin
							res_valid = 1'b1;
							res_kind  = wavp_pkg::KIND_ERROR;
							res_code  = wavp_pkg::ERR_NO_DATA;
							phase_d   = PH_DONE;
						end else begin
							fs_d    = 4'd0;
							tag_d   = 32'd0;
							len_d   = 32'd0;
							phase_d = (cr_q == 33'd0) ? PH_CHDR : PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				if (cr_q <= 33'd1) begin
					cr_d    = 33'd0;
					fs_d    = 4'd0;
					tag_d   = 32'd0;
					len_d   = 32'd0;
					phase_d = PH_CHDR;
				end else begin
					cr_d = cr_q - 33'd1;
				end
			end
			PH_DATA: begin
				if (fs_q == 4'd0) begin
					low_d = byte_s1;
					fs_d  = 4'd1;
				end else begin
					fs_d       = 4'd0;
					res_valid  = 1'b1;
					res_kind   = wavp_pkg::KIND_SAMPLE;
					res_sample = {byte_s1, low_q};
					cr_d       = cr_data;
					if (cr_data == 33'd0) begin
						res_last = 1'b1;
						phase_d  = PH_DONE;
					end
				end
			end
			default: begin
				// done: drop bytes until the file ends
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			kind_s2   <= res_kind;
			sample_s2 <= res_sample;
			last_s2   <= res_last;
			code_s2   <= (res_kind == wavp_pkg::KIND_ERROR) ? res_code : 4'd0;
			chan_s2   <= chan_q;
			rate_s2   <= rate_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_len_q <= 32'd0;
			rem_q      <= 32'd0;
			phase_q    <= PH_HEADER;
			fs_q       <= 4'd0;
			cr_q       <= 33'd0;
			fmt_seen_q <= 1'b0;
			chan_q     <= 16'd0;
			rate_q     <= 32'd0;
			low_q      <= 8'd0;
			tag_q      <= 32'd0;
			len_q      <= 32'd0;
			word_q     <= 32'd0;
		end else if (cfg_we || (step && restart)) begin
			// new length or end of file: start over at offset zero
			if (cfg_we) begin
				file_len_q <= file_length;
				rem_q      <= file_length;
			end else begin
				rem_q      <= file_len_q;
			end
			phase_q    <= PH_HEADER;
			fs_q       <= 4'd0;
			cr_q       <= 33'd0;
			fmt_seen_q <= 1'b0;
			chan_q     <= 16'd0;
			rate_q     <= 32'd0;
			low_q      <= 8'd0;
			tag_q      <= 32'd0;
			len_q      <= 32'd0;
			word_q     <= 32'd0;
		end else if (step) begin
			rem_q      <= rem_q - 32'd1;
			phase_q    <= phase_d;
			fs_q       <= fs_d;
			cr_q       <= cr_d;
			fmt_seen_q <= fmt_seen_d;
			chan_q     <= chan_d;
			rate_q     <= rate_d;
			low_q      <= low_d;
			tag_q      <= tag_d;
			len_q      <= len_d;
			word_q     <= word_d;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = kind_s2;
	assign sample        = sample_s2;
	assign is_last       = last_s2;
	assign error_code    = code_s2;
	assign channel_count = chan_s2;
	assign rate_hz       = rate_s2;

`ifndef SYNTHESIS
	a_data_needs_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> fmt_seen_q)
		else $error("data phase without a parsed fmt chunk");

	a_chdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHDR |-> fs_q < 4'd8)
		else $error("chunk header byte count out of range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= file_len_q)
		else $error("remaining byte count exceeds file length");

	a_last_is_sample: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && last_s2 |-> kind_s2 == wavp_pkg::KIND_SAMPLE && code_s2 == 4'd0)
		else $error("last flag on a word that is not a sample");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> cr_q != 33'd0)
		else $error("skip phase with nothing to skip");
`endif

endmodule
